/* src/rit_pkg.sv */
// shared types and codes of the reference counted id table
package rit_pkg;

	localparam int unsigned ID_W     = 32;
	localparam int unsigned NFRAME_W = 20;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned FRAME_W  = 20;
	localparam int unsigned REFS_W   = 16;

	typedef enum logic {
		OP_OPEN  = 1'b0,
		OP_CLOSE = 1'b1
	} rit_op_t;

	typedef enum logic [2:0] {
		ST_ATTACHED   = 3'd0,
		ST_CREATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_STILL_USED = 3'd3,
		ST_FREED      = 3'd4,
		ST_NOT_FOUND  = 3'd5,
		ST_INVALID    = 3'd6
	} rit_status_t;

	typedef struct packed {
		rit_op_t               operation;
		logic [ID_W-1:0]       region_id;
		logic [NFRAME_W-1:0]   new_frame;
	} rit_req_t;

	typedef struct packed {
		rit_status_t           status;
		logic [SLOT_W-1:0]     slot;
		logic [FRAME_W-1:0]    frame;
		logic [REFS_W-1:0]     ref_count;
	} rit_rsp_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                  active;
		logic                  done;
		logic                  has_empty;
		logic [SLOT_W-1:0]     empty_slot;
		rit_rsp_t              result;
	} rit_link_t;

endpackage

/* src/rit_if.sv */
// request and response channel interfaces
interface rit_req_if;
	logic              valid;
	logic              ready;
	rit_pkg::rit_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rit_rsp_if;
	logic              valid;
	logic              ready;
	rit_pkg::rit_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/rit_cell.sv */
// one table entry with its stage of the search chain
module rit_cell #(
	parameter int unsigned IDX        = 0,
	parameter int unsigned FRAME_BITS = 20,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rit_pkg::rit_req_t  req,
	input  logic               fill_en,
	input  rit_pkg::rit_link_t link_in,
	output rit_pkg::rit_link_t link_out
);
	import rit_pkg::*;

	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

	logic [ID_W-1:0]       ident_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [COUNT_BITS-1:0] refs_q;
	logic                  claim_q;
	rit_link_t             link_q;
	rit_link_t             nxt;
	logic                  hit;
	logic                  first_empty;
	logic [COUNT_BITS-1:0] refs_inc;
	logic [COUNT_BITS-1:0] refs_dec;

	assign hit         = link_in.active && !link_in.done && (ident_q == req.region_id);
	assign first_empty = link_in.active && !link_in.has_empty && (ident_q == '0);
	assign refs_inc    = (refs_q == CMAX) ? refs_q : refs_q + ONE;
	assign refs_dec    = refs_q - ONE;

	always_comb begin
		nxt = link_in;
		if (first_empty) begin
			nxt.has_empty  = 1'b1;
			nxt.empty_slot = SLOT_W'(IDX);
		end
		if (hit) begin
			nxt.done        = 1'b1;
			nxt.result.slot = SLOT_W'(IDX);
			if (req.operation == OP_OPEN) begin
				nxt.result.status    = ST_ATTACHED;
				nxt.result.frame     = FRAME_W'(frame_q);
				nxt.result.ref_count = REFS_W'(refs_inc);
			end else if (refs_q > ONE) begin
				nxt.result.status    = ST_STILL_USED;
				nxt.result.frame     = FRAME_W'(frame_q);
				nxt.result.ref_count = REFS_W'(refs_dec);
			end else begin
				nxt.result.status    = ST_FREED;
				nxt.result.frame     = '0;
				nxt.result.ref_count = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= '0;
			claim_q <= 1'b0;
			ident_q <= '0;
			frame_q <= '0;
			refs_q  <= '0;
		end else begin
			link_q <= nxt;
			if (link_in.active) begin
				claim_q <= first_empty;
			end
			if (fill_en && claim_q) begin
				ident_q <= req.region_id;
				frame_q <= FRAME_BITS'(req.new_frame);
				refs_q  <= ONE;
			end else if (hit) begin
				if (req.operation == OP_OPEN) begin
					refs_q <= refs_inc;
				end else if (refs_q > ONE) begin
					refs_q <= refs_dec;
				end else begin
					ident_q <= '0;
					frame_q <= '0;
					refs_q  <= '0;
				end
			end
		end
	end

	assign link_out = link_q;

endmodule

/* src/refcounted_id_table.sv */
// Reference counted id table: TABLE_ENTRIES cells in a row, each holding one entry
// (identifier, frame, count). A request with a nonzero identifier launches a search
// token that moves one cell per cycle; the matching cell updates itself as the token
// passes, and the lowest empty cell marks itself so an open miss can claim it as the
// token reaches the end of the chain. One item is in work at a time: a new request is
// taken only once the last result has moved to the output register; the search time is
// set by the length of the cell chain, and an identifier of zero skips the search.
// The result waits in an output register, and all entries are empty after reset.
module refcounted_id_table #(
	parameter int unsigned TABLE_ENTRIES = 64,
	parameter int unsigned FRAME_BITS    = 20,
	parameter int unsigned COUNT_BITS    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rit_req_if.sink       request,
	rit_rsp_if.source     response
);
	import rit_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	localparam rit_rsp_t INVALID_RSP = '{status: ST_INVALID, slot: '0, frame: '0,
		ref_count: '0};

	state_t    state_q;
	rit_req_t  req_q;
	logic      start_q;
	rit_rsp_t  res_q;
	logic      rsp_valid_q;
	rit_rsp_t  rsp_data_q;
	rit_link_t links [TABLE_ENTRIES+1];
	rit_link_t head;
	rit_link_t last;
	rit_rsp_t  final_res;
	logic      fill_en;
	logic      accept;

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;

	always_comb begin
		head        = '0;
		head.active = start_q;
	end

	assign links[0] = head;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		rit_cell #(
			.IDX        (i),
			.FRAME_BITS (FRAME_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.fill_en  (fill_en),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign last    = links[TABLE_ENTRIES];
	assign fill_en = last.active && !last.done && (req_q.operation == OP_OPEN) &&
		last.has_empty;

	always_comb begin
		final_res = '0;
		if (last.done) begin
			final_res = last.result;
		end else if (req_q.operation == OP_CLOSE) begin
			final_res.status = ST_NOT_FOUND;
		end else if (last.has_empty) begin
			final_res.status    = ST_CREATED;
			final_res.slot      = last.empty_slot;
			final_res.frame     = FRAME_W'(FRAME_BITS'(req_q.new_frame));
			final_res.ref_count = REFS_W'(1);
		end else begin
			final_res.status = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			req_q       <= '0;
			res_q       <= '0;
			rsp_data_q  <= '0;
		end else begin
			start_q <= accept && (request.data.region_id != '0);
			if (rsp_valid_q && response.ready && state_q != S_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= request.data;
						if (request.data.region_id == '0) begin
							res_q   <= INVALID_RSP;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last.active) begin
						res_q   <= final_res;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!rsp_valid_q || response.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign response.valid = rsp_valid_q;
	assign response.data  = rsp_data_q;

endmodule

/* src/rit_checker.sv */
// port level checks of the reference counted id table
module rit_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rit_pkg::rit_rsp_t rsp_data
);
	import rit_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_INVALID || rsp_data.status == ST_FULL ||
		rsp_data.status == ST_NOT_FOUND)
		|-> rsp_data.slot == '0 && rsp_data.frame == '0 && rsp_data.ref_count == '0)
		else $error("untouched entry result carries data");

	a_freed_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_FREED
		|-> rsp_data.frame == '0 && rsp_data.ref_count == '0)
		else $error("freed entry result carries frame or count");

	a_created_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_CREATED |-> rsp_data.ref_count == 16'd1)
		else $error("created entry count is not one");

endmodule

bind refcounted_id_table rit_checker u_rit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.rsp_valid (response.valid),
	.rsp_ready (response.ready),
	.rsp_data  (response.data)
);
